// ===== hw/rtl/nca_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, field types and control structs for the nearest-centroid block.
// Depends on nothing; every other file in hw/rtl refers to it by scoped names.

package nca_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int DIMENSIONS_DEF   = 4;
  localparam int DIMS_MAX         = 4;
  localparam int COORD_W          = 16;
  localparam int SEL_W            = 4;
  localparam int CFG_W            = 5;
  localparam int SQ_W             = 32;
  localparam int DIST_W           = 34;
  localparam int TOTAL_W          = 48;
  localparam int ACTIVE_RST       = 16;
  localparam int CMP_W            = 10;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIMS_MAX-1:0][COORD_W-1:0] coord_vec_t;

  typedef struct packed {
    logic load_we;
    logic capture;
    logic rd_en;
    logic rd_first;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/nca_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one load or classify transaction per valid/ready handshake.
// Depends on nca_pkg for field widths.

interface nca_in_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic        [nca_pkg::SEL_W-1:0]    cluster_sel;
  logic signed [nca_pkg::COORD_W-1:0]  coord_a;
  logic signed [nca_pkg::COORD_W-1:0]  coord_b;
  logic signed [nca_pkg::COORD_W-1:0]  coord_c;
  logic signed [nca_pkg::COORD_W-1:0]  coord_d;
  logic                                new_pass;

  modport source (
    output valid, mode, cluster_sel, coord_a, coord_b, coord_c, coord_d, new_pass,
    input  ready
  );
  modport sink (
    input  valid, mode, cluster_sel, coord_a, coord_b, coord_c, coord_d, new_pass,
    output ready
  );
endinterface

// ===== hw/rtl/nca_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: one classify result per valid/ready handshake.
// Depends on nca_pkg for field widths.

interface nca_out_if;
  logic                          valid;
  logic                          ready;
  logic [nca_pkg::SEL_W-1:0]     best_cluster;
  logic [nca_pkg::DIST_W-1:0]    best_distance;
  logic [nca_pkg::TOTAL_W-1:0]   pass_total;

  modport source (
    output valid, best_cluster, best_distance, pass_total,
    input  ready
  );
  modport sink (
    input  valid, best_cluster, best_distance, pass_total,
    output ready
  );
endinterface

// ===== hw/rtl/nca_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the active cluster count.
// Depends on nca_pkg for the register width.

interface nca_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nca_pkg::CFG_W-1:0]  data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

// ===== hw/rtl/nca_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences load writes, the centroid scan and result hand-off.
// Depends on nca_pkg for the command and status structs.

module nca_ctrl #(
  parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  output nca_pkg::cmd_t     cmd_o,
  input  nca_pkg::status_t  status_i,
  input  logic [IDX_W-1:0]  last_idx_i,
  output logic [IDX_W-1:0]  rd_addr_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign rd_addr_o  = idx_q;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i == nca_pkg::MODE_CLASSIFY) begin
            cmd_o.capture = 1'b1;
            idx_d         = '0;
            state_d       = ST_SCAN;
          end else begin
            cmd_o.load_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (idx_q == '0);
        if (idx_q == last_idx_i) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_finish_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!status_i.pipe_busy && status_i.out_free))
    else $error("finish issued with scan pipeline busy or output full");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q <= last_idx_i))
    else $error("scan index beyond active cluster range");

endmodule

// ===== hw/rtl/nca_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: centroid memory, distance pipeline, running minimum, total and output register.
// Depends on nca_pkg for field widths, coordinate types and control structs.

module nca_datapath #(
  parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
  parameter int DIMENSIONS   = nca_pkg::DIMENSIONS_DEF,
  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nca_pkg::cmd_t                 cmd_i,
  output nca_pkg::status_t              status_o,
  input  logic [IDX_W-1:0]              rd_addr_i,
  output logic [IDX_W-1:0]              last_idx_o,
  input  logic                          cfg_we_i,
  input  logic [nca_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [nca_pkg::SEL_W-1:0]     sel_i,
  input  nca_pkg::coord_vec_t           coords_i,
  input  logic                          new_pass_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nca_pkg::SEL_W-1:0]     best_cluster_o,
  output logic [nca_pkg::DIST_W-1:0]    best_distance_o,
  output logic [nca_pkg::TOTAL_W-1:0]   pass_total_o
);

  localparam int CMP_W   = nca_pkg::CMP_W;
  localparam int RST_CNT = (nca_pkg::ACTIVE_RST < MAX_CLUSTERS) ? nca_pkg::ACTIVE_RST
                                                                 : MAX_CLUSTERS;
  localparam int DW      = nca_pkg::COORD_W;

  // active count register
  logic [IDX_W-1:0]  last_idx_q;
  logic [CMP_W-1:0]  cnt_clamp;

  always_comb begin
    cnt_clamp = CMP_W'(cfg_data_i);
    if (cnt_clamp == '0) begin
      cnt_clamp = CMP_W'(1);
    end else if (cnt_clamp > CMP_W'(MAX_CLUSTERS)) begin
      cnt_clamp = CMP_W'(MAX_CLUSTERS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= IDX_W'(RST_CNT - 1);
    end else if (cfg_we_i) begin
      last_idx_q <= IDX_W'(cnt_clamp - CMP_W'(1));
    end
  end

  assign last_idx_o = last_idx_q;

  // point capture
  nca_pkg::coord_vec_t  point_q;
  logic                 new_pass_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      point_q    <= coords_i;
      new_pass_q <= new_pass_i;
    end
  end

  // centroid memory with per-entry valid bits
  nca_pkg::coord_vec_t  mem [MAX_CLUSTERS];
  logic [MAX_CLUSTERS-1:0] ent_vld_q;
  logic                 sel_ok;
  logic [IDX_W-1:0]     wr_idx;
  logic                 mem_we;
  nca_pkg::coord_vec_t  rd_data_q;

  assign sel_ok = CMP_W'(sel_i) < CMP_W'(MAX_CLUSTERS);
  assign wr_idx = IDX_W'(sel_i);
  assign mem_we = cmd_i.load_we && sel_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_idx] <= coords_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // stage 1: read data
  logic              s1_q, s1_first_q, s1_hit_q;
  logic [IDX_W-1:0]  s1_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      s1_q      <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_q[wr_idx] <= 1'b1;
      end
      s1_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      s1_first_q <= cmd_i.rd_first;
      s1_idx_q   <= rd_addr_i;
      s1_hit_q   <= ent_vld_q[rd_addr_i];
    end
  end

  // stage 2: per-lane squared differences
  nca_pkg::coord_vec_t  cent;
  logic [DW:0]          diff [nca_pkg::DIMS_MAX];
  logic [DW:0]          mag  [nca_pkg::DIMS_MAX];
  logic [nca_pkg::SQ_W-1:0] sq_d [nca_pkg::DIMS_MAX];
  logic [nca_pkg::SQ_W-1:0] sq_q [nca_pkg::DIMS_MAX];
  logic              s2_q, s2_first_q;
  logic [IDX_W-1:0]  s2_idx_q;

  assign cent = s1_hit_q ? rd_data_q : '0;

  always_comb begin
    for (int k = 0; k < nca_pkg::DIMS_MAX; k++) begin
      diff[k] = {point_q[k][DW-1], point_q[k]} - {cent[k][DW-1], cent[k]};
      mag[k]  = diff[k][DW] ? (~diff[k] + (DW+1)'(1)) : diff[k];
      if (k < DIMENSIONS) begin
        sq_d[k] = nca_pkg::SQ_W'(mag[k][DW-1:0]) * nca_pkg::SQ_W'(mag[k][DW-1:0]);
      end else begin
        sq_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= 1'b0;
    end else begin
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      sq_q       <= sq_d;
      s2_first_q <= s1_first_q;
      s2_idx_q   <= s1_idx_q;
    end
  end

  // stage 3: sum and running minimum
  logic [nca_pkg::DIST_W-1:0] dist_sum;
  logic [nca_pkg::DIST_W-1:0] best_d_q;
  logic [IDX_W-1:0]           best_i_q;

  always_comb begin
    dist_sum = '0;
    for (int k = 0; k < nca_pkg::DIMS_MAX; k++) begin
      dist_sum = dist_sum + nca_pkg::DIST_W'(sq_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q && (s2_first_q || (dist_sum < best_d_q))) begin
      best_d_q <= dist_sum;
      best_i_q <= s2_idx_q;
    end
  end

  // total and output register
  logic [nca_pkg::TOTAL_W-1:0] total_q, total_d, total_base;
  logic [nca_pkg::TOTAL_W:0]   total_sum;
  logic                        out_valid_q;
  logic [nca_pkg::SEL_W-1:0]   out_cluster_q;
  logic [nca_pkg::DIST_W-1:0]  out_dist_q;
  logic [nca_pkg::TOTAL_W-1:0] out_total_q;

  assign total_base = new_pass_q ? '0 : total_q;
  assign total_sum  = (nca_pkg::TOTAL_W+1)'(total_base) + (nca_pkg::TOTAL_W+1)'(best_d_q);
  assign total_d    = total_sum[nca_pkg::TOTAL_W] ? '1 : total_sum[nca_pkg::TOTAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_cluster_q <= nca_pkg::SEL_W'(best_i_q);
      out_dist_q    <= best_d_q;
      out_total_q   <= total_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign best_cluster_o   = out_cluster_q;
  assign best_distance_o  = out_dist_q;
  assign pass_total_o     = out_total_q;

  assign status_o.pipe_busy = s1_q || s2_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  a_total_covers_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_total_q >= nca_pkg::TOTAL_W'(out_dist_q)))
    else $error("total distance below the distance it includes");

  a_load_outside_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_we |-> (!s1_q && !s2_q && !cmd_i.rd_en))
    else $error("centroid write during a scan");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.finish))
    else $error("result raised without a finish command");

endmodule

// ===== hw/rtl/nearest_centroid_assign_core.sv =====
`timescale 1ns / 1ps
// Top level of the k-means assignment block: joins controller and datapath to the channels.
// Depends on nca_pkg, nca_in_if, nca_out_if, nca_cfg_if, nca_ctrl and nca_datapath.
//
//   port    dir   handshake     payload
//   in_i    sink  valid/ready   mode, cluster_sel, coord_a..coord_d, new_pass
//   out_o   src   valid/ready   best_cluster, best_distance, pass_total
//   cfg_i   sink  valid/ready   data (active cluster count, 5 bits)
//
// A load writes its centroid as it is taken. A classify scans N centroids before its
// result sits in the output register, N being the clamped active count: the single read
// port of the centroid memory delivers one centroid per cycle into a 3-stage pipe. No new
// transaction is taken until that result is written and the controller is idle again.
// Reset clears control, the total and the per-entry valid bits; no clearing pass.
// A stalled result holds in the output register while loads are still taken.

module nearest_centroid_assign_core #(
  parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
  parameter int DIMENSIONS   = nca_pkg::DIMENSIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nca_in_if.sink      in_i,
  nca_out_if.source   out_o,
  nca_cfg_if.sink     cfg_i
);

  localparam int IDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

  nca_pkg::cmd_t        cmd;
  nca_pkg::status_t     status;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     last_idx;
  nca_pkg::coord_vec_t  coords;
  logic                 in_ready;

  assign coords      = {in_i.coord_d, in_i.coord_c, in_i.coord_b, in_i.coord_a};
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  nca_ctrl #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status),
    .last_idx_i (last_idx),
    .rd_addr_o  (rd_addr)
  );

  nca_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .DIMENSIONS   (DIMENSIONS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .rd_addr_i        (rd_addr),
    .last_idx_o       (last_idx),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.data),
    .sel_i            (in_i.cluster_sel),
    .coords_i         (coords),
    .new_pass_i       (in_i.new_pass),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .best_cluster_o   (out_o.best_cluster),
    .best_distance_o  (out_o.best_distance),
    .pass_total_o     (out_o.pass_total)
  );

endmodule
